FILE: sv/e2c_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2c_pkg
// Shared constants, types and the arctangent table for the cube-map to
// equirectangular source address pipeline.
// ----------------------------------------------------------------------------
package e2c_pkg;

	// angle resolution: cordic iterations and kept angle bits
	localparam int ANGLE_BITS = 20;
	// cordic datapath width (scaled vector plus gain growth plus sign)
	localparam int CW = 34;
	// square root result bits, one per pipeline step
	localparam int SQRT_STEPS = 30;
	// width of x*x + y*y on the unscaled face vector
	localparam int SUMW = 28;
	// cordic pipeline depth: prerotation register plus one register per iteration
	localparam int CORDIC_LAT = ANGLE_BITS + 1;

	// configuration register indexes
	localparam logic [1:0] REG_FACE_SIZE     = 2'd0;
	localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd1;
	localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd2;

	// face selector codes
	localparam logic [2:0] MODE_BACK   = 3'd0;
	localparam logic [2:0] MODE_FRONT  = 3'd1;
	localparam logic [2:0] MODE_LEFT   = 3'd2;
	localparam logic [2:0] MODE_RIGHT  = 3'd3;
	localparam logic [2:0] MODE_TOP    = 3'd4;
	localparam logic [2:0] MODE_BOTTOM = 3'd5;

	// angles as fractions of a full turn
	localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
	localparam logic [31:0] THREE_QUARTS = 32'hC000_0000;

	// scaled direction vector traveling beside the square root
	typedef struct packed {
		logic               ok;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} side_t;

	// atan(2^-k) in 2^-32 turn units
	function automatic logic [31:0] atan_turn(input int k);
		logic [31:0] t;
		case (k)
			0:  t = 32'h20000000;
			1:  t = 32'h12E4051E;
			2:  t = 32'h09FB385B;
			3:  t = 32'h051111D4;
			4:  t = 32'h028B0D43;
			5:  t = 32'h0145D7E1;
			6:  t = 32'h00A2F61E;
			7:  t = 32'h00517C55;
			8:  t = 32'h0028BE53;
			9:  t = 32'h00145F2F;
			10: t = 32'h000A2F98;
			11: t = 32'h000517CC;
			12: t = 32'h00028BE6;
			13: t = 32'h000145F3;
			14: t = 32'h0000A2F9;
			15: t = 32'h0000517C;
			16: t = 32'h000028BE;
			17: t = 32'h0000145F;
			18: t = 32'h00000A2F;
			19: t = 32'h00000517;
			20: t = 32'h0000028B;
			21: t = 32'h00000145;
			22: t = 32'h000000A2;
			23: t = 32'h00000051;
			24: t = 32'h00000028;
			25: t = 32'h00000014;
			26: t = 32'h0000000A;
			27: t = 32'h00000005;
			28: t = 32'h00000002;
			29: t = 32'h00000001;
			default: t = 32'h00000000;
		endcase
		return t;
	endfunction

endpackage

FILE: sv/e2c_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2c_sqrt
// Pipelined digit-by-digit square root of (sum << 32), one result bit per
// stage, with the direction vector carried alongside.
// ----------------------------------------------------------------------------
module e2c_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [e2c_pkg::SUMW-1:0]  in_sum,
	input  e2c_pkg::side_t            in_side,
	output logic                      out_valid,
	output logic [e2c_pkg::SQRT_STEPS-1:0] out_root,
	output e2c_pkg::side_t            out_side
);

	localparam int STEPS = e2c_pkg::SQRT_STEPS;
	localparam int RW    = STEPS + 3;
	// the low 32 radicand bits are zero: 16 bit pairs
	localparam int ZERO_PAIRS = 16;

	logic                       v_s    [0:STEPS];
	logic [RW-1:0]              rem_s  [0:STEPS];
	logic [STEPS-1:0]           root_s [0:STEPS];
	logic [e2c_pkg::SUMW-1:0]   sum_s  [0:STEPS];
	e2c_pkg::side_t             side_s [0:STEPS];

	// load stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= '0;
		root_s[0] <= '0;
		sum_s[0]  <= in_sum;
		side_s[0] <= in_side;
	end

	// one root bit per stage
	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam int P = STEPS - 1 - k;
		logic [1:0]    pair;
		logic [RW-1:0] nrem;
		logic [RW-1:0] trial;
		logic          ge;

		if (P >= ZERO_PAIRS) begin : g_data
			assign pair = sum_s[k][2*(P-ZERO_PAIRS)+1 -: 2];
		end else begin : g_zero
			assign pair = 2'b00;
		end

		assign nrem  = {rem_s[k][RW-3:0], pair};
		assign trial = {1'b0, root_s[k], 2'b01};
		assign ge    = nrem >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? (nrem - trial) : nrem;
			root_s[k+1] <= {root_s[k][STEPS-2:0], ge};
			sum_s[k+1]  <= sum_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = v_s[STEPS];
	assign out_root  = root_s[STEPS];
	assign out_side  = side_s[STEPS];

endmodule

FILE: sv/e2c_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2c_cordic
// Pipelined cordic vectoring: angle of (x, y) as an unsigned fraction of a
// full turn, one iteration per stage, exact answers on the axes.
// ----------------------------------------------------------------------------
module e2c_cordic (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic signed [e2c_pkg::CW-1:0] in_y,
	input  logic signed [e2c_pkg::CW-1:0] in_x,
	output logic                         out_valid,
	output logic [31:0]                  out_angle
);

	localparam int AB = e2c_pkg::ANGLE_BITS;
	localparam int CW = e2c_pkg::CW;

	logic                 v_s   [0:AB];
	logic signed [CW-1:0] x_s   [0:AB];
	logic signed [CW-1:0] y_s   [0:AB];
	logic [31:0]          ang_s [0:AB];
	logic                 fix_s [0:AB];
	logic [1:0]           quad_s[0:AB];

	logic       axis_fix;
	logic [1:0] axis_quad;

	// axis directions give exact quarter turns
	always_comb begin
		axis_fix  = (in_y == '0) || (in_x == '0);
		if (in_y == '0) begin
			axis_quad = (in_x < 0) ? 2'd2 : 2'd0;
		end else begin
			axis_quad = (in_y > 0) ? 2'd1 : 2'd3;
		end
	end

	// prerotation into the right half plane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		fix_s[0]  <= axis_fix;
		quad_s[0] <= axis_quad;
		if (in_x < 0) begin
			x_s[0]   <= -in_x;
			y_s[0]   <= -in_y;
			ang_s[0] <= e2c_pkg::HALF_TURN;
		end else begin
			x_s[0]   <= in_x;
			y_s[0]   <= in_y;
			ang_s[0] <= '0;
		end
	end

	// one micro-rotation per stage
	for (genvar k = 0; k < AB; k++) begin : g_iter
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;

		assign dx = x_s[k] >>> k;
		assign dy = y_s[k] >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			fix_s[k+1]  <= fix_s[k];
			quad_s[k+1] <= quad_s[k];
			if (y_s[k] > 0) begin
				x_s[k+1]   <= x_s[k] + dy;
				y_s[k+1]   <= y_s[k] - dx;
				ang_s[k+1] <= ang_s[k] + e2c_pkg::atan_turn(k);
			end else begin
				x_s[k+1]   <= x_s[k] - dy;
				y_s[k+1]   <= y_s[k] + dx;
				ang_s[k+1] <= ang_s[k] - e2c_pkg::atan_turn(k);
			end
		end
	end

	assign out_valid = v_s[AB];
	assign out_angle = fix_s[AB] ? {quad_s[AB], 30'd0} : ang_s[AB];

endmodule

FILE: sv/equirect_to_cubemap_address.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// equirect_to_cubemap_address
// Source address generator for cube-map faces: face pixel -> direction
// vector -> (theta, phi) -> equirectangular row, column and linear index.
//
// channel   | signals                                  | handshake
// ----------+------------------------------------------+----------------------
// request   | mode, face_row, face_col                 | start, busy (always 0)
// result    | src_row, src_col, src_index, clamped     | done, one-cycle strobe
// config    | cfg_index, cfg_data                      | cfg_we
//
// One transaction enters per cycle; each result passes the face vector,
// squares and radicand stages, the bit-per-stage square root, the
// iteration-per-stage cordic, then the quantize, clamp, row-times-width
// and index stages. Reset clears only the valid bits and resets the config
// registers to their defaults; the pipeline never stalls, busy stays low.
// ----------------------------------------------------------------------------
module equirect_to_cubemap_address (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [11:0] face_row,
	input  logic [11:0] face_col,
	output logic        done,
	output logic [11:0] src_row,
	output logic [12:0] src_col,
	output logic [24:0] src_index,
	output logic        clamped,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [13:0] cfg_data
);

	localparam int AB    = e2c_pkg::ANGLE_BITS;
	localparam int CW    = e2c_pkg::CW;
	localparam int LAT_C = e2c_pkg::CORDIC_LAT;

	// configuration registers
	logic [12:0] face_size_q;
	logic [13:0] src_width_q;
	logic [12:0] src_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_size_q  <= 13'd512;
			src_width_q  <= 14'd2048;
			src_height_q <= 13'd1024;
		end else if (cfg_we) begin
			unique case (cfg_index)
				e2c_pkg::REG_FACE_SIZE:     face_size_q  <= cfg_data[12:0];
				e2c_pkg::REG_SOURCE_WIDTH:  src_width_q  <= cfg_data;
				e2c_pkg::REG_SOURCE_HEIGHT: src_height_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: face vector
	logic signed [14:0] a_c, b_c, n_c;
	logic signed [14:0] x_c, y_c, z_c;
	logic               ok_c;

	always_comb begin
		n_c  = $signed({2'b00, face_size_q});
		a_c  = $signed({2'b00, face_col, 1'b0}) - n_c;
		b_c  = $signed({2'b00, face_row, 1'b0}) - n_c;
		ok_c = 1'b1;
		x_c  = '0;
		y_c  = '0;
		z_c  = '0;
		unique case (mode)
			e2c_pkg::MODE_BACK:   begin x_c = n_c;  y_c = a_c;  z_c = -b_c; end
			e2c_pkg::MODE_FRONT:  begin x_c = -n_c; y_c = -a_c; z_c = -b_c; end
			e2c_pkg::MODE_LEFT:   begin x_c = -a_c; y_c = n_c;  z_c = -b_c; end
			e2c_pkg::MODE_RIGHT:  begin x_c = a_c;  y_c = -n_c; z_c = -b_c; end
			e2c_pkg::MODE_TOP:    begin x_c = -b_c; y_c = -a_c; z_c = n_c;  end
			e2c_pkg::MODE_BOTTOM: begin x_c = b_c;  y_c = -a_c; z_c = -n_c; end
			default:              ok_c = 1'b0;
		endcase
	end

	logic               v_s1, ok_s1;
	logic signed [14:0] x_s1, y_s1, z_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		ok_s1 <= ok_c;
		x_s1  <= x_c;
		y_s1  <= y_c;
		z_s1  <= z_c;
	end

	// stage 2: squares
	logic               v_s2, ok_s2;
	logic signed [14:0] x_s2, y_s2, z_s2;
	logic signed [29:0] sqx_s2, sqy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		ok_s2  <= ok_s1;
		x_s2   <= x_s1;
		y_s2   <= y_s1;
		z_s2   <= z_s1;
		sqx_s2 <= x_s1 * x_s1;
		sqy_s2 <= y_s1 * y_s1;
	end

	// stage 3: radicand and scaled vector
	logic                     v_s3;
	logic [e2c_pkg::SUMW-1:0] sum_s3;
	e2c_pkg::side_t           side_s3;
	logic [29:0]              sum_c;

	assign sum_c = sqx_s2 + sqy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sum_s3     <= sum_c[e2c_pkg::SUMW-1:0];
		side_s3.ok <= ok_s2;
		side_s3.x  <= {{1{x_s2[14]}}, x_s2, 16'd0};
		side_s3.y  <= {{1{y_s2[14]}}, y_s2, 16'd0};
		side_s3.z  <= {{1{z_s2[14]}}, z_s2, 16'd0};
	end

	// radial length
	logic                           sq_v;
	logic [e2c_pkg::SQRT_STEPS-1:0] sq_root;
	e2c_pkg::side_t                 sq_side;

	e2c_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s3),
		.in_sum   (sum_s3),
		.in_side  (side_s3),
		.out_valid(sq_v),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	// azimuth and polar angle in parallel
	logic        phi_v, th_v;
	logic [31:0] phi, theta;

	e2c_cordic u_phi (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sq_v),
		.in_y     ({{(CW-32){sq_side.y[31]}}, sq_side.y}),
		.in_x     ({{(CW-32){sq_side.x[31]}}, sq_side.x}),
		.out_valid(phi_v),
		.out_angle(phi)
	);

	e2c_cordic u_theta (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sq_v),
		.in_y     ($signed({{(CW-e2c_pkg::SQRT_STEPS){1'b0}}, sq_root})),
		.in_x     ({{(CW-32){sq_side.z[31]}}, sq_side.z}),
		.out_valid(th_v),
		.out_angle(theta)
	);

	// face-valid flag beside the cordic
	logic ok_d [0:LAT_C-1];

	always_ff @(posedge clk) begin
		ok_d[0] <= sq_side.ok;
		for (int i = 1; i < LAT_C; i++) begin
			ok_d[i] <= ok_d[i-1];
		end
	end

	// stage 4: theta overshoot, quantize, scale by image size
	logic [31:0]    th_fix;
	logic [AB-1:0]  thq, phq;
	logic [AB+12:0] rp_c;
	logic [AB+13:0] cp_c;

	always_comb begin
		th_fix = theta;
		if (theta > e2c_pkg::HALF_TURN) begin
			th_fix = (theta >= e2c_pkg::THREE_QUARTS) ? 32'd0 : e2c_pkg::HALF_TURN;
		end
		thq  = th_fix[31 -: AB];
		phq  = phi[31 -: AB];
		rp_c = {{AB{1'b0}}, src_height_q} * {13'd0, thq};
		cp_c = {{AB{1'b0}}, src_width_q} * {14'd0, phq};
	end

	logic           v_s4, ok_s4;
	logic [AB+12:0] rp_s4;
	logic [AB+13:0] cp_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= th_v;
		end
	end

	always_ff @(posedge clk) begin
		ok_s4 <= ok_d[LAT_C-1];
		rp_s4 <= rp_c;
		cp_s4 <= cp_c;
	end

	// stage 5: clamp to the image
	logic [11:0] rlim_c;
	logic [12:0] clim_c;
	logic [13:0] row_w, col_w;

	always_comb begin
		if (src_height_q == '0) begin
			rlim_c = '0;
		end else if (src_height_q > 13'd4096) begin
			rlim_c = 12'd4095;
		end else begin
			rlim_c = 12'(src_height_q - 13'd1);
		end
		if (src_width_q == '0) begin
			clim_c = '0;
		end else if (src_width_q > 14'd8192) begin
			clim_c = 13'd8191;
		end else begin
			clim_c = 13'(src_width_q - 14'd1);
		end
		row_w = rp_s4[AB+12:AB-1];
		col_w = cp_s4[AB+13:AB];
	end

	logic        v_s5, ok_s5, clamp_s5;
	logic [11:0] row_s5;
	logic [12:0] col_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		ok_s5    <= ok_s4;
		row_s5   <= (row_w > {2'b00, rlim_c}) ? rlim_c : row_w[11:0];
		col_s5   <= (col_w > {1'b0, clim_c}) ? clim_c : col_w[12:0];
		clamp_s5 <= (row_w > {2'b00, rlim_c}) || (col_w > {1'b0, clim_c});
	end

	// stage 6: row times width
	logic        v_s6, ok_s6, clamp_s6;
	logic [11:0] row_s6;
	logic [12:0] col_s6;
	logic [25:0] prod_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		ok_s6    <= ok_s5;
		clamp_s6 <= clamp_s5;
		row_s6   <= row_s5;
		col_s6   <= col_s5;
		prod_s6  <= {14'd0, row_s5} * {12'd0, src_width_q};
	end

	// stage 7: linear index and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (ok_s6) begin
			src_row   <= row_s6;
			src_col   <= col_s6;
			src_index <= prod_s6[24:0] + {12'd0, col_s6};
			clamped   <= clamp_s6;
		end else begin
			src_row   <= '0;
			src_col   <= '0;
			src_index <= '0;
			clamped   <= 1'b0;
		end
	end

	// checks
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (src_row <= rlim_c))
		else $error("source row beyond limit");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (src_col <= clim_c))
		else $error("source column beyond limit");

	a_cordic_align: assert property (@(posedge clk) disable iff (!arst_n)
		phi_v == th_v)
		else $error("azimuth and polar cordic out of step");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cube-map source address generator. Face pixel
// transactions are fed through a randomly gapped driver, each accepted one is
// projected by a behavioral CORDIC/square-root model, and every done strobe
// is compared field by field against the oldest projected address.
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct packed {
		logic [2:0]  mode;
		logic [11:0] row;
		logic [11:0] col;
	} pixel_t;

	typedef struct packed {
		logic [11:0] row;
		logic [12:0] col;
		logic [24:0] index;
		logic        clamped;
	} src_addr_t;

	logic        clk, arst_n, start, busy, done, clamped, cfg_we;
	logic [2:0]  mode;
	logic [11:0] face_row, face_col, src_row;
	logic [12:0] src_col;
	logic [24:0] src_index;
	logic [1:0]  cfg_index;
	logic [13:0] cfg_data;

	equirect_to_cubemap_address dut (.*);

	// arctangent of 2^-k in 2^-32 turn units
	logic [31:0] atan_lut [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
		32'h00000000, 32'h00000000};

	// configuration as seen by the predictor
	logic [12:0] cur_face;
	logic [13:0] cur_width;
	logic [12:0] cur_height;

	pixel_t    pending_pixels[$];
	src_addr_t expected_addrs[$];
	int        idle_pct;
	int        mismatches, checked, accepted, stall_cycles;

	// clock
	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	function automatic logic [63:0] isqrt(logic [63:0] v);
		logic [63:0] res, probe;
		res = 0;
		probe = 64'd1 << 62;
		while (probe > v) probe >>= 2;
		while (probe != 0) begin
			if (v >= res + probe) begin
				v -= res + probe;
				res = (res >> 1) + probe;
			end else begin
				res >>= 1;
			end
			probe >>= 2;
		end
		return res;
	endfunction

	// angle of (x, y) in turn units by cordic vectoring
	function automatic logic [31:0] turn_of(longint y, longint x);
		logic [31:0] ang;
		longint dx, dy;
		ang = 0;
		if (y == 0) return (x < 0) ? e2c_pkg::HALF_TURN : 32'h0;
		if (x == 0) return (y > 0) ? 32'h4000_0000 : e2c_pkg::THREE_QUARTS;
		if (x < 0) begin
			x = -x;
			y = -y;
			ang = e2c_pkg::HALF_TURN;
		end
		for (int k = 0; k < e2c_pkg::ANGLE_BITS && k < 32; k++) begin
			dx = x >>> k;
			dy = y >>> k;
			if (y > 0) begin
				x += dy; y -= dx; ang += atan_lut[k];
			end else begin
				x -= dy; y += dx; ang -= atan_lut[k];
			end
		end
		return ang;
	endfunction

	function automatic src_addr_t project_pixel(pixel_t p);
		src_addr_t res;
		longint n, a, b, x, y, z;
		logic [63:0] r, phq, thq, srow, scol, rlim, clim, w, h;
		logic [31:0] phi, theta;
		res = '0;
		n = cur_face;
		a = 2 * longint'(p.col) - n;
		b = 2 * longint'(p.row) - n;
		case (p.mode)
			e2c_pkg::MODE_BACK:   begin x = n;  y = a;  z = -b; end
			e2c_pkg::MODE_FRONT:  begin x = -n; y = -a; z = -b; end
			e2c_pkg::MODE_LEFT:   begin x = -a; y = n;  z = -b; end
			e2c_pkg::MODE_RIGHT:  begin x = a;  y = -n; z = -b; end
			e2c_pkg::MODE_TOP:    begin x = -b; y = -a; z = n;  end
			e2c_pkg::MODE_BOTTOM: begin x = b;  y = -a; z = -n; end
			default:              return res;
		endcase
		x *= 65536; y *= 65536; z *= 65536;
		r = isqrt(x * x + y * y);
		phi = turn_of(y, x);
		theta = turn_of(longint'(r), z);
		// overshoot past either pole is pinned to that pole
		if (theta > e2c_pkg::HALF_TURN)
			theta = (theta >= e2c_pkg::THREE_QUARTS) ? 32'h0 : e2c_pkg::HALF_TURN;
		phq = phi >> (32 - e2c_pkg::ANGLE_BITS);
		thq = theta >> (32 - e2c_pkg::ANGLE_BITS);
		w = cur_width;
		h = cur_height;
		srow = (h * thq) >> (e2c_pkg::ANGLE_BITS - 1);
		scol = (w * phq) >> e2c_pkg::ANGLE_BITS;
		rlim = (h != 0) ? h - 1 : 0;
		if (rlim > 4095) rlim = 4095;
		clim = (w != 0) ? w - 1 : 0;
		if (clim > 8191) clim = 8191;
		if (srow > rlim) begin srow = rlim; res.clamped = 1'b1; end
		if (scol > clim) begin scol = clim; res.clamped = 1'b1; end
		res.row = srow[11:0];
		res.col = scol[12:0];
		res.index = 25'(srow * w + scol);
		return res;
	endfunction

	// driver: records accepted transactions, then presents the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			mode <= '0;
			face_row <= '0;
			face_col <= '0;
		end else begin
			if (start && !busy) begin
				expected_addrs = {expected_addrs,
					project_pixel({mode, face_row, face_col})};
				void'(pending_pixels.pop_front());
				accepted++;
			end
			if (pending_pixels.size() > 0 && $urandom_range(99) >= idle_pct) begin
				start <= 1'b1;
				{mode, face_row, face_col} <= pending_pixels[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (expected_addrs.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result at %0t: %0d %0d %0d %0d", $time,
							src_row, src_col, src_index, clamped);
				end else begin
					src_addr_t e;
					e = expected_addrs.pop_front();
					checked++;
					if (e != {src_row, src_col, src_index, clamped}) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp row %0d col %0d idx %0d clamp %0d,",
								" got %0d %0d %0d %0d"},
								e.row, e.col, e.index, e.clamped,
								src_row, src_col, src_index, clamped);
					end
				end
			end
			stall_cycles = ((start && !busy) || done) ? 0 : stall_cycles + 1;
			if (stall_cycles >= 5000) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic write_dims(int face, int width, int height);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_index <= e2c_pkg::REG_FACE_SIZE; cfg_data <= 14'(face);
		@(posedge clk);
		cfg_index <= e2c_pkg::REG_SOURCE_WIDTH; cfg_data <= 14'(width);
		@(posedge clk);
		cfg_index <= e2c_pkg::REG_SOURCE_HEIGHT; cfg_data <= 14'(height);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_face = 13'(face);
		cur_width = 14'(width);
		cur_height = 13'(height);
	endtask

	task automatic drain();
		wait (pending_pixels.size() == 0 && expected_addrs.size() == 0);
		repeat (70) @(posedge clk);
	endtask

	initial begin
		int faces [8]   = '{512, 4096, 1, 0, 7, 8191, 100, 64};
		int widths [8]  = '{2048, 8192, 1, 0, 13, 16383, 777, 640};
		int heights [8] = '{1024, 4096, 1, 0, 9, 8191, 333, 320};
		int lim;
		pixel_t p;
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		idle_pct = 17;
		mismatches = 0; checked = 0; accepted = 0; stall_cycles = 0;
		cur_face = 13'd512; cur_width = 14'd2048; cur_height = 13'd1024;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < 8; ph++) begin
			idle_pct = (ph < 3) ? 17 : (ph < 6) ? 56 : 0;
			write_dims(faces[ph], widths[ph], heights[ph]);
			// corners, face centers (axis and pole cases), far edge, unused modes
			if (ph == 0)
				for (int m = 0; m < 8; m++) begin
					pending_pixels = {pending_pixels, pixel_t'({3'(m), 12'd0, 12'd0})};
					pending_pixels = {pending_pixels, pixel_t'({3'(m), 12'd256, 12'd256})};
					pending_pixels = {pending_pixels, pixel_t'({3'(m), 12'd511, 12'd4095})};
				end
			for (int i = 0; i < 50; i++) begin
				p.mode = 3'($urandom_range(0, 99) < 92 ?
					$urandom_range(0, 5) : $urandom_range(6, 7));
				lim = (cur_face == 0 || $urandom_range(0, 9) == 0) ? 4095 : cur_face - 1;
				if (lim > 4095) lim = 4095;
				p.row = 12'($urandom_range(0, lim));
				p.col = 12'($urandom_range(0, lim));
				pending_pixels = {pending_pixels, p};
			end
			drain();
		end

		$display("checked %0d of %0d transactions over 8 geometry settings,", checked, accepted);
		$display("including all faces, unused modes, zero and maximum dimensions");
		if (mismatches == 0 && expected_addrs.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

FILE: filelist.f
sv/e2c_pkg.sv
sv/e2c_sqrt.sv
sv/e2c_cordic.sv
sv/equirect_to_cubemap_address.sv
tb/tb_top.sv
